// ----- rtl/pbe_pkg.sv -----
package pbe_pkg;

   // Buffer geometry
   localparam int DEPTH       = 16;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int OCC_W       = $clog2(DEPTH + 1);
   localparam int NUM_CLASSES = 3;

   // Command queue between front end and execution unit
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // Field widths
   localparam int VALUE_W  = 32;
   localparam int CLASS_W  = 2;
   localparam int EXPIRY_W = 16;
   localparam int TIME_W   = 32;
   localparam int FILL_W   = 5;

   // Stream widths
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 80;

   // Operation codes carried in req_tuser
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Class code that is never stored
   localparam logic [CLASS_W-1:0] CLASS_NONE = '0;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  value;
      logic        [CLASS_W-1:0]  cls;
      logic        [TIME_W-1:0]   created;
      logic        [EXPIRY_W-1:0] expiry;
   } entry_type;

   typedef struct packed {
      logic                       is_remove;
      logic                       bad_class;
      logic signed [VALUE_W-1:0]  value;
      logic        [CLASS_W-1:0]  cls;
      logic        [EXPIRY_W-1:0] expiry;
      logic        [TIME_W-1:0]   now_ms;
   } cmd_type;

   typedef struct packed {
      logic                       accepted;
      logic signed [VALUE_W-1:0]  out_value;
      logic        [CLASS_W-1:0]  out_priority;
      logic                       expired;
      logic signed [VALUE_W-1:0]  class_sum;
      logic        [FILL_W-1:0]   fill_count;
   } result_type;

endpackage

// ----- rtl/pbe_front.sv -----
module pbe_front
   import pbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output cmd_type               cmd_data
);

   logic    valid_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;

   // Decode and classify the incoming transfer
   always_comb begin
      cmd_in.is_remove = (req_tuser == OP_REMOVE);
      cmd_in.value     = req_tdata[31:0];
      cmd_in.cls       = req_tdata[33:32];
      cmd_in.expiry    = req_tdata[49:34];
      cmd_in.now_ms    = req_tdata[81:50];
      cmd_in.bad_class = (req_tdata[33:32] == CLASS_NONE);
   end

   assign req_tready = !valid_ff || cmd_ready;
   assign cmd_valid  = valid_ff;
   assign cmd_data   = cmd_ff;

   // Input holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ----- rtl/pbe_cmd_fifo.sv -----
module pbe_cmd_fifo
   import pbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type              slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff;
   logic [CMD_PTR_W-1:0] rd_ptr_ff;
   logic [CMD_CNT_W-1:0] count_ff;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = (count_ff != CMD_CNT_W'(CMD_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and count bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                         : wr_ptr_ff + CMD_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                         : rd_ptr_ff + CMD_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CMD_CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CMD_CNT_W'(1);
         end
      end
   end

   // Payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/pbe_back.sv -----
module pbe_back
   import pbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   output logic       cmd_pop,
   input  cmd_type    cmd_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   state_type                 state_ff;
   logic [OCC_W-1:0]          occ_ff;
   logic signed [VALUE_W-1:0] sums_ff [NUM_CLASSES];
   cmd_type                   cur_ff;
   entry_type                 best_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic [IDX_W-1:0]          rd_idx_ff;
   logic                      expired_ff;
   logic                      rsp_valid_ff;
   result_type                rsp_ff;

   // Entry storage, one read and one write port
   entry_type                 mem [DEPTH];
   entry_type                 rd_data_ff;

   logic                      out_free;
   logic                      has_room;
   logic [OCC_W-1:0]          occ_m1;
   logic [IDX_W-1:0]          last_idx;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   entry_type                 wr_data;
   logic [TIME_W-1:0]         elapsed;
   logic [CLASS_W-1:0]        sum_sel;
   logic signed [VALUE_W-1:0] sum_new;
   entry_type                 new_entry;
   logic                      rsp_load;
   result_type                early_rsp;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid && out_free;
   assign has_room  = (occ_ff < OCC_W'(DEPTH));
   assign occ_m1    = occ_ff - OCC_W'(1);
   assign last_idx  = occ_m1[IDX_W-1:0];
   assign elapsed   = cur_ff.now_ms - best_ff.created;
   assign sum_sel   = best_ff.cls - CLASS_W'(1);
   assign sum_new   = expired_ff ? sums_ff[sum_sel] : sums_ff[sum_sel] + best_ff.value;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A response is loaded for inserts and empty removes, or at the end of a remove
   assign rsp_load  = (cmd_pop && (!cmd_data.is_remove || occ_ff == '0))
                      || (state_ff == ST_FINISH && out_free);

   always_comb begin
      new_entry.value   = cmd_data.value;
      new_entry.cls     = cmd_data.cls;
      new_entry.created = cmd_data.now_ms;
      new_entry.expiry  = cmd_data.expiry;
   end

   // Response for a command that completes in the idle state
   always_comb begin
      early_rsp = '0;
      if (!cmd_data.is_remove) begin
         if (!cmd_data.bad_class && has_room) begin
            early_rsp.accepted   = 1'b1;
            early_rsp.fill_count = FILL_W'(occ_ff + OCC_W'(1));
         end else begin
            early_rsp.fill_count = FILL_W'(occ_ff);
         end
      end
   end

   // Memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = new_entry;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               if (!cmd_data.is_remove && !cmd_data.bad_class && has_room) begin
                  wr_en   = 1'b1;
                  wr_addr = occ_ff[IDX_W-1:0];
               end
               if (cmd_data.is_remove && occ_ff != '0) begin
                  rd_en = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff != last_idx) begin
               rd_en   = 1'b1;
               rd_addr = rd_idx_ff + IDX_W'(1);
            end
         end
         ST_CHECK: begin
            if (best_idx_ff != last_idx) begin
               rd_en   = 1'b1;
               rd_addr = best_idx_ff + IDX_W'(1);
            end
         end
         ST_SHIFT: begin
            // move the entry just read one place toward the head
            wr_en   = 1'b1;
            wr_addr = rd_idx_ff - IDX_W'(1);
            wr_data = rd_data_ff;
            if (rd_idx_ff != last_idx) begin
               rd_en   = 1'b1;
               rd_addr = rd_idx_ff + IDX_W'(1);
            end
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Sequencer: scan for the best entry, check expiry, close the gap, report
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_pop) begin
                  cur_ff <= cmd_data;
                  rsp_ff <= early_rsp;
                  if (!cmd_data.is_remove) begin
                     if (!cmd_data.bad_class && has_room) begin
                        occ_ff <= occ_ff + OCC_W'(1);
                     end
                  end else if (occ_ff != '0) begin
                     rd_idx_ff <= '0;
                     state_ff  <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               // strict compare keeps the oldest entry of a class
               if (rd_idx_ff == '0 || rd_data_ff.cls < best_ff.cls) begin
                  best_ff     <= rd_data_ff;
                  best_idx_ff <= rd_idx_ff;
               end
               if (rd_idx_ff == last_idx) begin
                  state_ff <= ST_CHECK;
               end else begin
                  rd_idx_ff <= rd_idx_ff + IDX_W'(1);
               end
            end
            ST_CHECK: begin
               expired_ff <= (elapsed > TIME_W'(best_ff.expiry));
               if (best_idx_ff == last_idx) begin
                  state_ff <= ST_FINISH;
               end else begin
                  rd_idx_ff <= best_idx_ff + IDX_W'(1);
                  state_ff  <= ST_SHIFT;
               end
            end
            ST_SHIFT: begin
               if (rd_idx_ff == last_idx) begin
                  state_ff <= ST_FINISH;
               end else begin
                  rd_idx_ff <= rd_idx_ff + IDX_W'(1);
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  sums_ff[sum_sel]    <= sum_new;
                  occ_ff              <= occ_m1;
                  rsp_ff.accepted     <= 1'b1;
                  rsp_ff.out_value    <= best_ff.value;
                  rsp_ff.out_priority <= best_ff.cls;
                  rsp_ff.expired      <= expired_ff;
                  rsp_ff.class_sum    <= sum_new;
                  rsp_ff.fill_count   <= FILL_W'(occ_m1);
                  state_ff            <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- rtl/priority_buffer_with_expiry_core.sv -----
// An insert or a refused request passes the input holding register, the command
// queue and the response register. A remove runs a one-entry-per-cycle scan of
// the entry memory, then a shift pass through the same port, before the next
// command is taken. Inserts go at one item per cycle while responses are taken.
// Reset (synchronous, active high) empties the buffer and clears the class sums.
module priority_buffer_with_expiry_core
   import pbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,  // action
   input  logic [REQ_DATA_W-1:0] req_tdata,  // value, priority_req, expiry_ms, now_ms
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accepted, out_value, out_priority, expired, class_sum, fill_count
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       cmd_valid;
   logic       cmd_ready;
   cmd_type    cmd_data;
   logic       q_valid;
   logic       q_pop;
   cmd_type    q_data;
   result_type result;

   pbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd_data   (cmd_data)
   );

   pbe_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_ready (cmd_ready),
      .push_data  (cmd_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_data   (q_data)
   );

   pbe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_pop   (q_pop),
      .cmd_data  (q_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (result)
   );

   // Pack the result transfer
   assign rsp_tdata = {7'b0, result.fill_count, result.class_sum, result.expired,
                       result.out_priority, result.out_value, result.accepted};

endmodule
